/* design/swm_pkg.sv */
// Shared constants and types of the two-way sorted merge block.
package swm_pkg;

  // Storage sizes: entries per side queue and element width.
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MERGED   = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Side codes.
  localparam logic SIDE_A = 1'b0;
  localparam logic SIDE_B = 1'b1;

  // One classified input word on its way from the front to the back.
  typedef struct packed {
    logic                          side;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          has_value;
    logic                          last;
  } cmd_t;

  // One result word as held in the output register.
  typedef struct packed {
    status_e                       status;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          side;
    logic                          fin;
  } res_t;

endpackage

/* design/swm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module swm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/swm_front.sv */
// Front end: takes input words, drops those that carry nothing, and queues the rest.
module swm_front import swm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          side_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          has_value_i,
  input  logic                          last_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output cmd_t                          cmd_o
);

  cmd_t       ent0_q, ent1_q;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] fill_q, fill_d;
  logic       accept, keep, push, pop;
  cmd_t       cmd_in;

  // A word with neither an element nor an end flag leaves the state unchanged.
  assign cmd_in     = '{side: side_i, value: value_i, has_value: has_value_i, last: last_i};
  assign in_ready_o = (fill_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign keep       = has_value_i || last_i;
  assign push       = accept && keep;
  assign pop        = cmd_valid_o && cmd_ready_i;

  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = rd_q ? ent1_q : ent0_q;

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop ? ~rd_q : rd_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // Queue entries hold payload only.
  always_ff @(posedge clk_i) begin
    if (push && !wr_q) begin
      ent0_q <= cmd_in;
    end
    if (push && wr_q) begin
      ent1_q <= cmd_in;
    end
  end

endmodule

/* design/swm_back.sv */
// Back end: applies queued words to the side queues and runs the merge.
module swm_back import swm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FETCH  = 3'b010,
    S_DECIDE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [PTR_W-1:0]  rd_a_q, rd_a_d, rd_b_q, rd_b_d;
  logic [PTR_W-1:0]  wr_a_q, wr_a_d, wr_b_q, wr_b_d;
  logic              ended_a_q, ended_a_d, ended_b_q, ended_b_d;
  logic              emitted_q, emitted_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic              res_load, out_free, go_idle;
  logic              we_a, we_b;
  logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;
  logic              a_nz, b_nz, take, pick_b, fin, side_ended;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Side queues; the read address is always the head pointer.
  swm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wr_a_q),
    .wdata_i (cmd_i.value),
    .raddr_i (rd_a_q),
    .rdata_o (rdata_a)
  );

  swm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wr_b_q),
    .wdata_i (cmd_i.value),
    .raddr_i (rd_b_q),
    .rdata_o (rdata_b)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Merge choice from the registered heads; ties go to side A.
  always_comb begin
    a_nz   = (cnt_a_q != '0);
    b_nz   = (cnt_b_q != '0);
    take   = 1'b0;
    pick_b = 1'b0;
    if (a_nz && b_nz) begin
      take   = 1'b1;
      pick_b = !($signed(rdata_a) <= $signed(rdata_b));
    end else if (ended_a_q && !a_nz && b_nz && (cnt_b_q > CNT_W'(1) || ended_b_q)) begin
      take   = 1'b1;
      pick_b = 1'b1;
    end else if (ended_b_q && !b_nz && a_nz && (cnt_a_q > CNT_W'(1) || ended_a_q)) begin
      take   = 1'b1;
      pick_b = 1'b0;
    end
    fin = ended_a_q && ended_b_q &&
          (pick_b ? (cnt_b_q == CNT_W'(1) && !a_nz) : (cnt_a_q == CNT_W'(1) && !b_nz));
  end

  assign side_ended = cmd_i.side ? ended_b_q : ended_a_q;

  // Sequencer: apply one word, then emit merged elements until none is ready.
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    rd_a_d      = rd_a_q;
    rd_b_d      = rd_b_q;
    wr_a_d      = wr_a_q;
    wr_b_d      = wr_b_q;
    ended_a_d   = ended_a_q;
    ended_b_d   = ended_b_q;
    emitted_d   = emitted_q;
    cmd_ready_o = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    res_load    = 1'b0;
    res_d       = res_q;
    go_idle     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          if (!side_ended) begin
            state_d = S_FETCH;
            if (cmd_i.has_value) begin
              if ((cmd_i.side ? cnt_b_q : cnt_a_q) == CNT_W'(DEPTH)) begin
                res_load = 1'b1;
                res_d    = '{status: ST_OVERFLOW, value: '0, side: cmd_i.side, fin: 1'b0};
              end else if (cmd_i.side == SIDE_B) begin
                we_b    = 1'b1;
                wr_b_d  = ptr_inc(wr_b_q);
                cnt_b_d = cnt_b_q + CNT_W'(1);
              end else begin
                we_a    = 1'b1;
                wr_a_d  = ptr_inc(wr_a_q);
                cnt_a_d = cnt_a_q + CNT_W'(1);
              end
            end
            if (cmd_i.last) begin
              if (cmd_i.side == SIDE_B) begin
                ended_b_d = 1'b1;
              end else begin
                ended_a_d = 1'b1;
              end
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (take) begin
          if (out_free) begin
            res_load  = 1'b1;
            emitted_d = 1'b1;
            if (pick_b) begin
              res_d   = '{status: ST_MERGED, value: $signed(rdata_b), side: SIDE_B, fin: fin};
              rd_b_d  = ptr_inc(rd_b_q);
              cnt_b_d = cnt_b_q - CNT_W'(1);
            end else begin
              res_d   = '{status: ST_MERGED, value: $signed(rdata_a), side: SIDE_A, fin: fin};
              rd_a_d  = ptr_inc(rd_a_q);
              cnt_a_d = cnt_a_q - CNT_W'(1);
            end
            if (fin) begin
              go_idle = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_FETCH;
            end
          end
        end else if (ended_a_q && ended_b_q && !a_nz && !b_nz) begin
          // Both sides ended with nothing left: report an empty merge once if no element was emitted.
          if (emitted_q) begin
            go_idle = 1'b1;
            state_d = S_IDLE;
          end else if (out_free) begin
            res_load = 1'b1;
            res_d    = '{status: ST_EMPTY, value: '0, side: SIDE_A, fin: 1'b1};
            go_idle  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (go_idle) begin
      cnt_a_d   = '0;
      cnt_b_d   = '0;
      rd_a_d    = '0;
      rd_b_d    = '0;
      wr_a_d    = '0;
      wr_b_d    = '0;
      ended_a_d = 1'b0;
      ended_b_d = 1'b0;
      emitted_d = 1'b0;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      rd_a_q      <= '0;
      rd_b_q      <= '0;
      wr_a_q      <= '0;
      wr_b_q      <= '0;
      ended_a_q   <= 1'b0;
      ended_b_q   <= 1'b0;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      rd_a_q      <= rd_a_d;
      rd_b_q      <= rd_b_d;
      wr_a_q      <= wr_a_d;
      wr_b_q      <= wr_b_d;
      ended_a_q   <= ended_a_d;
      ended_b_q   <= ended_b_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Fill levels never pass the queue depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_W'(DEPTH)) && (cnt_b_q <= CNT_W'(DEPTH)))
    else $error("side queue fill level above depth");

  // A result is only loaded into a free or draining output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result overwrote a pending output word");

  // After the final result the merge state is back at idle.
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_d.fin) |=> (state_q == S_IDLE) && (cnt_a_q == '0) &&
      (cnt_b_q == '0) && !ended_a_q && !ended_b_q)
    else $error("merge state not cleared after final result");

  // A merged element always comes from a non-empty side.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_d.status == ST_MERGED) |->
      (res_d.side ? (cnt_b_q != '0) : (cnt_a_q != '0)))
    else $error("element taken from an empty side");

endmodule

/* design/sorted_two_way_merge.sv */
// Top level of the two-way merge of ascending sequences A and B.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   side_i, value_i, has_value_i, last_i
//   output    out_valid_o / out_ready_i status_o, value_res_o, from_side_o, final_res_o
//
// The front takes one word per cycle into a two-entry queue while the queue is not full.
// The back drops a word on an ended side at once; else it applies the word, then fetches and decides,
// and each merged element from the registered RAM read is fetched and decided anew unless it ends the merge.
// Reset is asynchronous and active low; it clears control state, not RAM contents.
// A stalled output holds its word in the output register and the back waits.
module sorted_two_way_merge import swm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          side_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          has_value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [VALUE_WIDTH-1:0] value_res_o,
  output logic                          from_side_o,
  output logic                          final_res_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  swm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .side_i      (side_i),
    .value_i     (value_i),
    .has_value_i (has_value_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  swm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Unpack the result word onto the output ports.
  assign status_o    = res.status;
  assign value_res_o = res.value;
  assign from_side_o = res.side;
  assign final_res_o = res.fin;

endmodule

/* bench/sorted_two_way_merge_test.sv */
// Self-checking testbench of the two-way sorted merge block.
module sorted_two_way_merge_test;
  import swm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam int RAND_WORDS  = 75;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 40;
  localparam int TAIL_CYCLES = 40;

  // One input word as queued for the driver.
  typedef struct {
    logic                          sd;
    logic signed [VALUE_WIDTH-1:0] val;
    logic                          hv;
    logic                          lst;
    bit                            drain_first;
  } word_t;

  // One expected result word.
  typedef struct {
    status_e                       st;
    logic signed [VALUE_WIDTH-1:0] val;
    logic                          sd;
    logic                          fin;
  } merged_t;

  logic                          clk_i = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready_o;
  logic                          side = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic                          has_value = 1'b0;
  logic                          last = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready = 1'b0;
  logic [1:0]                    status_o;
  logic signed [VALUE_WIDTH-1:0] value_res_o;
  logic                          from_side_o;
  logic                          final_res_o;

  // Words waiting to be sent and results waiting to arrive.
  word_t   word_q[$];
  merged_t merged_out_q[$];

  // Shadow copy of the block's merge state.
  logic signed [VALUE_WIDTH-1:0] side_a_q[$];
  logic signed [VALUE_WIDTH-1:0] side_b_q[$];
  bit ended_a, ended_b, seen_elem;

  int n_errors  = 0;
  int n_got     = 0;
  int tx_wait   = 0;
  int tx_calm   = 0;
  int rx_wait   = 0;
  int rx_calm   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  sorted_two_way_merge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .side_i      (side),
    .value_i     (value),
    .has_value_i (has_value),
    .last_i      (last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .value_res_o (value_res_o),
    .from_side_o (from_side_o),
    .final_res_o (final_res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  // Gap before the next word; zero while a calm stretch lasts.
  function automatic int pick_gap(input int calm);
    return (calm > 0) ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic int next_calm(input int calm);
    if (calm > 0) return calm - 1;
    return ($urandom_range(0, 15) == 0) ? 24 : 0;
  endfunction

  task automatic push_merged(input status_e st, input logic signed [VALUE_WIDTH-1:0] val,
                             input logic sd, input logic fin);
    merged_t r;
    r.st  = st;
    r.val = val;
    r.sd  = sd;
    r.fin = fin;
    merged_out_q.push_back(r);
  endtask

  task automatic clear_merge();
    side_a_q.delete();
    side_b_q.delete();
    ended_a   = 1'b0;
    ended_b   = 1'b0;
    seen_elem = 1'b0;
  endtask

  // Apply one accepted word to the shadow state and queue the results it causes.
  task automatic merge_word(input logic sd, input logic signed [VALUE_WIDTH-1:0] val,
                            input logic hv, input logic lst);
    logic                          pick;
    bit                            found;
    logic signed [VALUE_WIDTH-1:0] e;
    logic                          fin;
    // Words for a side that already ended are dropped silently.
    if (sd == SIDE_A ? ended_a : ended_b) return;
    if (hv) begin
      if ((sd == SIDE_A ? side_a_q.size() : side_b_q.size()) >= DEPTH)
        push_merged(ST_OVERFLOW, '0, sd, 1'b0);
      else if (sd == SIDE_A)
        side_a_q.push_back(val);
      else
        side_b_q.push_back(val);
    end
    if (lst) begin
      if (sd == SIDE_A) ended_a = 1'b1;
      else ended_b = 1'b1;
    end
    // Emit while a choice is safe; a lone side keeps its newest element until it ends.
    found = 1'b1;
    while (found) begin
      found = 1'b1;
      if (side_a_q.size() > 0 && side_b_q.size() > 0) begin
        pick = (side_a_q[0] <= side_b_q[0]) ? SIDE_A : SIDE_B;
      end else if (ended_a && side_a_q.size() == 0 && side_b_q.size() > 0 &&
                   (side_b_q.size() > 1 || ended_b)) begin
        pick = SIDE_B;
      end else if (ended_b && side_b_q.size() == 0 && side_a_q.size() > 0 &&
                   (side_a_q.size() > 1 || ended_a)) begin
        pick = SIDE_A;
      end else begin
        found = 1'b0;
      end
      if (found) begin
        if (pick == SIDE_A) e = side_a_q.pop_front();
        else e = side_b_q.pop_front();
        seen_elem = 1'b1;
        fin = ended_a && ended_b && side_a_q.size() == 0 && side_b_q.size() == 0;
        push_merged(ST_MERGED, e, pick, fin);
        if (fin) begin
          clear_merge();
          return;
        end
      end
    end
    if (ended_a && ended_b && side_a_q.size() == 0 && side_b_q.size() == 0) begin
      if (!seen_elem) push_merged(ST_EMPTY, '0, SIDE_A, 1'b1);
      clear_merge();
    end
  endtask

  task automatic add_word(input logic sd, input logic signed [VALUE_WIDTH-1:0] val,
                          input logic hv, input logic lst);
    word_t w;
    w.sd          = sd;
    w.val         = val;
    w.hv          = hv;
    w.lst         = lst;
    w.drain_first = 1'b0;
    word_q.push_back(w);
  endtask

  // Build the words of one side: n values in the given style, then its end unless no_end is set.
  task automatic build_side(input logic sd, input int n, input int mode, input bit no_end,
                            output word_t seq[$]);
    int    vals[$];
    int    corner_vals[7];
    bit    sep;
    word_t w;
    corner_vals = '{int'(VAL_MIN), int'(VAL_MIN) + 1, -1, 0, 1, int'(VAL_MAX) - 1,
                    int'(VAL_MAX)};
    seq = {};
    sep = (n == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      case (mode)
        1:       vals.push_back(int'($urandom_range(0, 8)) - 4);
        3:       vals.push_back(corner_vals[$urandom_range(0, 6)]);
        default: vals.push_back($urandom);
      endcase
    end
    // Style 2 leaves the values unsorted.
    if (mode != 2) vals.sort();
    for (int i = 0; i < n; i++) begin
      w.sd          = sd;
      w.val         = vals[i];
      w.hv          = 1'b1;
      w.lst         = (i == n - 1) && !sep && !no_end;
      w.drain_first = 1'b0;
      seq.push_back(w);
    end
    if (sep && !no_end) begin
      w.sd          = sd;
      w.val         = $urandom;
      w.hv          = 1'b0;
      w.lst         = 1'b1;
      w.drain_first = 1'b0;
      seq.push_back(w);
    end
  endtask

  // Queue one merge with random lengths, value style and interleaving; returns its word count.
  task automatic add_merge(output int n_words);
    word_t la[$];
    word_t lb[$];
    int    order;
    bit    take_a;
    int    na, nb;
    na = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 19) : $urandom_range(0, 5);
    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 19) : $urandom_range(0, 5);
    build_side(SIDE_A, na, $urandom_range(0, 3), $urandom_range(0, 24) == 0, la);
    build_side(SIDE_B, nb, $urandom_range(0, 3), 1'b0, lb);
    n_words = la.size() + lb.size();
    order = $urandom_range(0, 4);
    while (la.size() > 0 || lb.size() > 0) begin
      if (la.size() == 0) take_a = 1'b0;
      else if (lb.size() == 0) take_a = 1'b1;
      else begin
        case (order)
          1:       take_a = 1'b1;
          2:       take_a = 1'b0;
          3:       take_a = ($urandom_range(0, 3) != 0);
          default: take_a = $urandom_range(0, 1);
        endcase
      end
      if (take_a) word_q.push_back(la.pop_front());
      else word_q.push_back(lb.pop_front());
      // Now and then a stray word for a side that has just run out.
      if (la.size() == 0 && lb.size() > 0 && $urandom_range(0, 4) == 0)
        add_word(SIDE_A, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
      else if (lb.size() == 0 && la.size() > 0 && $urandom_range(0, 4) == 0)
        add_word(SIDE_B, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // Driver: offers queued words and predicts each accepted one.
  always @(posedge clk_i or negedge rst_n) begin : tx_proc
    word_t w;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      side      <= 1'b0;
      value     <= '0;
      has_value <= 1'b0;
      last      <= 1'b0;
      tx_wait   <= 0;
    end else begin
      if (in_valid && in_ready_o) merge_word(side, value, has_value, last);
      if (!in_valid || in_ready_o) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait  <= tx_wait - 1;
        end else if (word_q.size() > 0 &&
                     (!word_q[0].drain_first || merged_out_q.size() == 0)) begin
          w = word_q.pop_front();
          side      <= w.sd;
          value     <= w.val;
          has_value <= w.hv;
          last      <= w.lst;
          in_valid  <= 1'b1;
          tx_wait   <= pick_gap(tx_calm);
          tx_calm   = next_calm(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and paces the ready line.
  always @(posedge clk_i or negedge rst_n) begin : rx_proc
    int      nw;
    merged_t r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      nw = rx_wait;
      if (out_valid_o && out_ready) begin
        if (merged_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d value %0d side %0d fin %0d",
                                    status_o, value_res_o, from_side_o, final_res_o));
        end else begin
          r = merged_out_q.pop_front();
          if (status_o !== r.st || value_res_o !== r.val || from_side_o !== r.sd ||
              final_res_o !== r.fin)
            report_mismatch($sformatf(
              "got status %0d value %0d side %0d fin %0d, want %0d %0d %0d %0d",
              status_o, value_res_o, from_side_o, final_res_o, r.st, r.val, r.sd, r.fin));
        end
        n_got++;
        nw = pick_gap(rx_calm);
        rx_calm = next_calm(rx_calm);
      end
      // One long hold-off lets the block back up into its input.
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_got >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (nw > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= nw - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait   <= 0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : main_proc
    int n_rand;
    int n_words;
    int first_rand;
    // Both sequences empty.
    add_word(SIDE_A, $urandom, 1'b0, 1'b1);
    add_word(SIDE_B, $urandom, 1'b0, 1'b1);
    // Extreme values with ties at both ends, and a word for an ended side.
    add_word(SIDE_A, VAL_MIN, 1'b1, 1'b0);
    add_word(SIDE_B, VAL_MIN, 1'b1, 1'b0);
    add_word(SIDE_A, VAL_MAX, 1'b1, 1'b1);
    add_word(SIDE_A, '0, 1'b1, 1'b0);
    add_word(SIDE_B, VAL_MAX, 1'b1, 1'b1);
    // Fill side A, overflow on the word that ends it, then drain on a bare end of B.
    for (int i = 0; i < DEPTH; i++) add_word(SIDE_A, i * 3 - 20, 1'b1, 1'b0);
    add_word(SIDE_A, 100, 1'b1, 1'b1);
    add_word(SIDE_A, 5, 1'b1, 1'b1);
    add_word(SIDE_B, $urandom, 1'b0, 1'b1);
    // Random merges; the first one waits for every earlier result.
    first_rand = word_q.size();
    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      add_merge(n_words);
      n_rand += n_words;
    end
    if (word_q.size() > first_rand) word_q[first_rand].drain_first = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid) @(posedge clk_i);
    while (merged_out_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200us;
    $display("status: fail");
    $finish;
  end

endmodule
